@@ rtl/anfp_pkg.sv @@
// ----------------------------------------------------------------------------
// anfp_pkg: shared types and constants of the AVC NAL FU-A packetizer
// Parse phases, queue entry layout, output beat codes, FU-A header constants.
// ----------------------------------------------------------------------------
package anfp_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_FIELD_BYTES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MTU_BYTES          = 1'b1;

	localparam logic [2:0]  LFB_RESET = 3'd4;
	localparam logic [15:0] MTU_RESET = 16'd1400;
	localparam logic [15:0] MTU_MIN   = 16'd3;

	// FU-A header fields
	localparam logic [7:0] NRI_MASK  = 8'he0;
	localparam logic [7:0] FUA_TYPE  = 8'd28;
	localparam logic [7:0] TYPE_MASK = 8'h1f;
	localparam int         FU_S_BIT  = 7;
	localparam int         FU_E_BIT  = 6;

	typedef enum logic [5:0] {
		PH_PREFIX = 6'b000001,
		PH_SKIP   = 6'b000010,
		PH_DROP   = 6'b000100,
		PH_SINGLE = 6'b001000,
		PH_FUHEAD = 6'b010000,
		PH_FUBODY = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		BEAT_IND  = 2'd0,
		BEAT_HDR  = 2'd1,
		BEAT_DATA = 2'd2
	} beat_t;

	// one request from the front to the back: a payload byte, optionally
	// preceded by the FU-A indicator and header bytes
	typedef struct packed {
		logic       with_hdr;
		logic [7:0] ind;
		logic [7:0] hdr;
		logic [7:0] data;
		logic       first;
		logic       last;
		logic       mark;
		logic       trunc;
	} entry_t;

	function automatic logic [2:0] clamp_lfb(input logic [2:0] v);
		logic [2:0] r;
		r = v;
		if (v == 3'd0)
			r = 3'd1;
		else if (v inside {[3'd5:3'd7]})
			r = 3'd4;
		return r;
	endfunction

	function automatic logic [15:0] clamp_mtu(input logic [15:0] v);
		return (v < MTU_MIN) ? MTU_MIN : v;
	endfunction

endpackage

@@ rtl/anfp_front.sv @@
// ----------------------------------------------------------------------------
// anfp_front: length prefix parser and packet classifier
// Tracks the NAL state per accepted byte and pushes one request per byte
// that produces output.
// ----------------------------------------------------------------------------
module anfp_front #(
	parameter int BUFFER_LENGTH_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [7:0]                    data_byte,
	input  logic [BUFFER_LENGTH_BITS-1:0] buffer_length,
	input  logic                          last_of_buffer,
	input  logic [2:0]                    lfb,
	input  logic [15:0]                   mtu,
	input  logic [15:0]                   cap,
	output logic                          push,
	output anfp_pkg::entry_t              entry
);

	localparam int NW = BUFFER_LENGTH_BITS;

	anfp_pkg::phase_t phase_q, phase_d;
	logic [31:0]   acc_q, acc_d;
	logic [2:0]    seen_q, seen_d;
	logic [NW-1:0] nal_left_q, nal_left_d;
	logic [15:0]   frag_q, frag_d;
	logic [7:0]    ind_q, ind_d;
	logic [4:0]    type_q, type_d;
	logic          first_pend_q, first_pend_d;

	logic [31:0]   acc_nxt;
	logic [2:0]    seen_inc;
	logic [NW-1:0] cap_ext, fl_wide;
	logic [15:0]   frag_cur;
	logic          frag_zero, nal_done, fend, trunc, last_c, push_c;

	always_comb begin
		acc_nxt   = {acc_q[23:0], data_byte};
		seen_inc  = seen_q + 3'd1;
		cap_ext   = NW'(cap);
		fl_wide   = (nal_left_q < cap_ext) ? nal_left_q : cap_ext;
		frag_zero = (frag_q == 16'd0);
		frag_cur  = frag_zero ? fl_wide[15:0] : frag_q;
		nal_done  = (nal_left_q == NW'(1));
		fend      = (frag_cur == 16'd1);
		trunc     = last_of_buffer && !nal_done;
		last_c    = 1'b0;

		phase_d      = phase_q;
		acc_d        = acc_q;
		seen_d       = seen_q;
		nal_left_d   = nal_left_q;
		frag_d       = frag_q;
		ind_d        = ind_q;
		type_d       = type_q;
		first_pend_d = first_pend_q;
		push_c       = 1'b0;
		entry        = '0;

		case (phase_q)
			anfp_pkg::PH_SKIP: begin
				phase_d = anfp_pkg::PH_PREFIX;
				acc_d   = '0;
				seen_d  = '0;
			end
			anfp_pkg::PH_DROP: begin
			end
			anfp_pkg::PH_SINGLE: begin
				last_c       = nal_done || last_of_buffer;
				first_pend_d = 1'b0;
				nal_left_d   = nal_left_q - NW'(1);
				push_c       = 1'b1;
				entry.data   = data_byte;
				entry.first  = first_pend_q;
				entry.last   = last_c;
				entry.mark   = last_c;
				entry.trunc  = trunc;
				if (nal_done) begin
					phase_d = anfp_pkg::PH_PREFIX;
					acc_d   = '0;
					seen_d  = '0;
				end
			end
			anfp_pkg::PH_FUHEAD: begin
				ind_d        = (data_byte & anfp_pkg::NRI_MASK) | anfp_pkg::FUA_TYPE;
				type_d       = 5'(data_byte & anfp_pkg::TYPE_MASK);
				nal_left_d   = nal_left_q - NW'(1);
				frag_d       = '0;
				first_pend_d = 1'b1;
				phase_d      = anfp_pkg::PH_FUBODY;
			end
			anfp_pkg::PH_FUBODY: begin
				last_c         = fend || last_of_buffer;
				push_c         = 1'b1;
				entry.with_hdr = frag_zero;
				entry.ind      = ind_q;
				entry.hdr      = {3'b000, type_q};
				entry.hdr[anfp_pkg::FU_S_BIT] = first_pend_q;
				entry.hdr[anfp_pkg::FU_E_BIT] = (fl_wide == nal_left_q);
				entry.data     = data_byte;
				entry.last     = last_c;
				entry.mark     = last_c && (nal_done || trunc);
				entry.trunc    = trunc;
				if (frag_zero)
					first_pend_d = 1'b0;
				frag_d     = frag_cur - 16'd1;
				nal_left_d = nal_left_q - NW'(1);
				if (nal_done) begin
					phase_d = anfp_pkg::PH_PREFIX;
					acc_d   = '0;
					seen_d  = '0;
				end
			end
			default: begin
				// prefix byte; undefined codes land here too
				phase_d = anfp_pkg::PH_PREFIX;
				if (seen_inc >= lfb) begin
					acc_d  = '0;
					seen_d = '0;
					if (acc_nxt == 32'd1) begin
						phase_d = anfp_pkg::PH_SKIP;
					end else if (acc_nxt == 32'd0 ||
						{1'b0, acc_nxt} > 33'(buffer_length)) begin
						phase_d = anfp_pkg::PH_DROP;
					end else if (acc_nxt <= {16'd0, mtu}) begin
						nal_left_d   = NW'(acc_nxt);
						first_pend_d = 1'b1;
						phase_d      = anfp_pkg::PH_SINGLE;
					end else begin
						nal_left_d = NW'(acc_nxt);
						phase_d    = anfp_pkg::PH_FUHEAD;
					end
				end else begin
					acc_d  = acc_nxt;
					seen_d = seen_inc;
				end
			end
		endcase

		// end of buffer always returns to prefix parsing
		if (last_of_buffer) begin
			phase_d = anfp_pkg::PH_PREFIX;
			acc_d   = '0;
			seen_d  = '0;
		end
	end

	assign push = accept && push_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= anfp_pkg::PH_PREFIX;
			acc_q        <= '0;
			seen_q       <= '0;
			nal_left_q   <= '0;
			frag_q       <= '0;
			ind_q        <= '0;
			type_q       <= '0;
			first_pend_q <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_d;
			acc_q        <= acc_d;
			seen_q       <= seen_d;
			nal_left_q   <= nal_left_d;
			frag_q       <= frag_d;
			ind_q        <= ind_d;
			type_q       <= type_d;
			first_pend_q <= first_pend_d;
		end
	end

`ifndef ASSERT_OFF
	a_open_nal_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == anfp_pkg::PH_SINGLE || phase_q == anfp_pkg::PH_FUBODY)
		|-> nal_left_q != '0)
		else $error("open NAL with no bytes left");
`endif

endmodule

@@ rtl/anfp_fifo.sv @@
// ----------------------------------------------------------------------------
// anfp_fifo: request queue between front and back
// Small register file queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module anfp_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  anfp_pkg::entry_t wr_entry,
	input  logic             pop,
	output anfp_pkg::entry_t rd_entry,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	anfp_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue underflow");
`endif

endmodule

@@ rtl/anfp_back.sv @@
// ----------------------------------------------------------------------------
// anfp_back: output sequencer
// Holds one request in an output register and plays it out as one or three
// result beats (indicator, header, payload).
// ----------------------------------------------------------------------------
module anfp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  anfp_pkg::entry_t head,
	input  logic             q_empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       packet_byte,
	output logic             packet_first,
	output logic             packet_last,
	output logic             marker_bit,
	output logic             truncated,
	output logic             run_last
);

	anfp_pkg::entry_t cur_q;
	anfp_pkg::beat_t  beat_q;
	logic             busy_q;
	logic             step, done_beat;

	assign step      = busy_q && !out_stall;
	assign done_beat = step && (beat_q == anfp_pkg::BEAT_DATA);
	assign pop       = (!busy_q || done_beat) && !q_empty;
	assign out_valid = busy_q;

	always_comb begin
		packet_byte  = cur_q.data;
		packet_first = cur_q.first;
		packet_last  = cur_q.last;
		marker_bit   = cur_q.mark;
		truncated    = cur_q.trunc;
		run_last     = 1'b1;
		case (beat_q)
			anfp_pkg::BEAT_IND: begin
				packet_byte  = cur_q.ind;
				packet_first = 1'b1;
				packet_last  = 1'b0;
				marker_bit   = 1'b0;
				truncated    = 1'b0;
				run_last     = 1'b0;
			end
			anfp_pkg::BEAT_HDR: begin
				packet_byte  = cur_q.hdr;
				packet_first = 1'b0;
				packet_last  = 1'b0;
				marker_bit   = 1'b0;
				truncated    = 1'b0;
				run_last     = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beat_q <= anfp_pkg::BEAT_DATA;
		end else if (pop) begin
			busy_q <= 1'b1;
			beat_q <= head.with_hdr ? anfp_pkg::BEAT_IND : anfp_pkg::BEAT_DATA;
		end else if (done_beat) begin
			busy_q <= 1'b0;
		end else if (step) begin
			beat_q <= (beat_q == anfp_pkg::BEAT_IND) ? anfp_pkg::BEAT_HDR
				: anfp_pkg::BEAT_DATA;
		end
	end

`ifndef ASSERT_OFF
	a_hdr_beats_only_with_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && beat_q != anfp_pkg::BEAT_DATA) |-> cur_q.with_hdr)
		else $error("header beat on a request without FU-A header");
	a_hdr_follows_ind: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && beat_q == anfp_pkg::BEAT_IND && !out_stall)
		|=> (busy_q && beat_q == anfp_pkg::BEAT_HDR))
		else $error("FU-A header beat lost after indicator");
`endif

endmodule

@@ rtl/avc_nal_fua_packetizer_unit.sv @@
// ----------------------------------------------------------------------------
// avc_nal_fua_packetizer_unit: H.264 AVC NAL to RTP FU-A packetizer
// Front parser, request queue and output sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one byte of a length-prefixed buffer per
//   request, with the buffer length and an end-of-buffer flag.
//   Output channel (out_valid/out_stall): one packet byte per request, with
//   first/last flags, the RTP marker, a truncation flag and run_last marking
//   the final result caused by one input byte.
//   Configuration (cfg_we/cfg_index/cfg_wdata): write only while idle.
// Timing:
//   One input byte per cycle while in_stall is low; a byte that yields output
//   passes the request queue into the output register. The output sequencer
//   emits one result a cycle while out_stall is low; a byte that opens an FU-A
//   fragment yields three results, so the output side sets the sustained rate:
//   MTU results per MTU-2 payload bytes of a fragmented NAL. The request queue
//   (QUEUE_DEPTH entries) absorbs that burst; in_stall rises only while full.
// Reset: registers return to their defaults (4-byte prefix, MTU 1400) and the
// parser waits for a length prefix. A stalled output holds its result; input
// keeps flowing until the queue fills.
// ----------------------------------------------------------------------------
module avc_nal_fua_packetizer_unit #(
	parameter int BUFFER_LENGTH_BITS = 24,
	parameter int QUEUE_DEPTH        = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,

	// configuration write port
	input  logic                              cfg_we,
	input  logic [anfp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                       cfg_wdata,

	// input bytes
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        data_byte,
	input  logic [BUFFER_LENGTH_BITS-1:0]     buffer_length,
	input  logic                              last_of_buffer,

	// packet bytes
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        packet_byte,
	output logic                              packet_first,
	output logic                              packet_last,
	output logic                              marker_bit,
	output logic                              truncated,
	output logic                              run_last
);

	// configuration, stored already clamped to its legal range
	logic [2:0]  lfb_q;
	logic [15:0] mtu_q;
	logic [15:0] cap_q;    // largest FU-A payload: MTU minus indicator and header

	logic             accept;
	logic             push, pop, q_full, q_empty;
	anfp_pkg::entry_t push_entry, head_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfb_q <= anfp_pkg::LFB_RESET;
			mtu_q <= anfp_pkg::MTU_RESET;
			cap_q <= anfp_pkg::MTU_RESET - 16'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				anfp_pkg::CFG_LENGTH_FIELD_BYTES: begin
					lfb_q <= anfp_pkg::clamp_lfb(cfg_wdata[2:0]);
				end
				anfp_pkg::CFG_MTU_BYTES: begin
					mtu_q <= anfp_pkg::clamp_mtu(cfg_wdata);
					cap_q <= anfp_pkg::clamp_mtu(cfg_wdata) - 16'd2;
				end
				default: begin
				end
			endcase
		end
	end

	// the front takes a byte whenever the queue has room
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	anfp_front #(
		.BUFFER_LENGTH_BITS(BUFFER_LENGTH_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.data_byte      (data_byte),
		.buffer_length  (buffer_length),
		.last_of_buffer (last_of_buffer),
		.lfb            (lfb_q),
		.mtu            (mtu_q),
		.cap            (cap_q),
		.push           (push),
		.entry          (push_entry)
	);

	anfp_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.pop      (pop),
		.rd_entry (head_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	anfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head_entry),
		.q_empty      (q_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.packet_byte  (packet_byte),
		.packet_first (packet_first),
		.packet_last  (packet_last),
		.marker_bit   (marker_bit),
		.truncated    (truncated),
		.run_last     (run_last)
	);

endmodule

@@ bench/anfp_packet_checker.sv @@
// ----------------------------------------------------------------------------
// anfp_packet_checker: packet byte checker for the AVC NAL FU-A packetizer
// Watches the config port and both request channels, predicts the packet bytes
// each accepted input byte produces, and compares them in order.
// ----------------------------------------------------------------------------
module anfp_packet_checker #(
	parameter int BLEN_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [anfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_wdata,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [7:0]                     data_byte,
	input  logic [BLEN_BITS-1:0]           buffer_length,
	input  logic                           last_of_buffer,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [7:0]                     packet_byte,
	input  logic                           packet_first,
	input  logic                           packet_last,
	input  logic                           marker_bit,
	input  logic                           truncated,
	input  logic                           run_last,
	output int                             mismatches,
	output int                             beats_pending
);

	typedef struct packed {
		logic [7:0] pbyte;
		logic       first;
		logic       last;
		logic       mark;
		logic       trunc;
		logic       run_end;
	} pkt_beat_t;

	pkt_beat_t expected_beats[$];
	pkt_beat_t want;

	// shadow of the config registers
	logic [2:0]  lfb_reg;
	logic [15:0] mtu_reg;

	// parser state
	anfp_pkg::phase_t ph;
	logic [31:0] len_acc;
	logic [2:0]  pfx_seen;
	logic [31:0] nal_left;
	logic [15:0] frag_left;
	logic [7:0]  fu_ind;
	logic [4:0]  fu_type;
	logic        open_first;

	task automatic restart_prefix();
		ph = anfp_pkg::PH_PREFIX;
		len_acc = '0;
		pfx_seen = '0;
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, got_v);
			mismatches++;
		end
	endtask

	// one input byte -> zero to three packet bytes
	task automatic take_byte(input logic [7:0] b, input logic [BLEN_BITS-1:0] blen,
			input logic eob);
		pkt_beat_t   beats[3];
		int          n;
		logic [2:0]  lfb;
		logic [15:0] mtu;
		logic [15:0] cap;
		logic [15:0] flen;
		logic [7:0]  hdr;
		logic [31:0] sz;
		logic [63:0] blen_wide;
		logic        first, done, cut, close, frag_end;
		n = 0;
		blen_wide = blen;
		lfb = (lfb_reg == 3'd0) ? 3'd1 : ((lfb_reg > 3'd4) ? 3'd4 : lfb_reg);
		mtu = (mtu_reg < anfp_pkg::MTU_MIN) ? anfp_pkg::MTU_MIN : mtu_reg;
		case (ph)
			anfp_pkg::PH_SKIP: begin
				restart_prefix();
			end
			anfp_pkg::PH_DROP: begin
			end
			anfp_pkg::PH_SINGLE: begin
				first = open_first;
				open_first = 1'b0;
				nal_left--;
				done = (nal_left == 0);
				cut = eob && !done;
				close = done || eob;
				beats[n] = '{b, first, close, close, cut, 1'b0};
				n++;
				if (done)
					restart_prefix();
			end
			anfp_pkg::PH_FUHEAD: begin
				fu_ind = (b & anfp_pkg::NRI_MASK) | anfp_pkg::FUA_TYPE;
				fu_type = b[4:0];
				nal_left--;
				frag_left = '0;
				open_first = 1'b1;
				ph = anfp_pkg::PH_FUBODY;
			end
			anfp_pkg::PH_FUBODY: begin
				if (frag_left == 0) begin
					cap = mtu - 16'd2;
					flen = (nal_left < {16'h0, cap}) ? nal_left[15:0] : cap;
					hdr = {3'b000, fu_type};
					if (open_first)
						hdr[anfp_pkg::FU_S_BIT] = 1'b1;
					if ({16'h0, flen} == nal_left)
						hdr[anfp_pkg::FU_E_BIT] = 1'b1;
					open_first = 1'b0;
					frag_left = flen;
					beats[n] = '{fu_ind, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
					n++;
					beats[n] = '{hdr, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
					n++;
				end
				frag_left--;
				nal_left--;
				done = (nal_left == 0);
				frag_end = (frag_left == 0);
				cut = eob && !done;
				close = frag_end || eob;
				beats[n] = '{b, 1'b0, close, close && (done || cut), cut, 1'b0};
				n++;
				if (done)
					restart_prefix();
			end
			default: begin
				// length prefix, big-endian; odd codes land here too
				ph = anfp_pkg::PH_PREFIX;
				len_acc = {len_acc[23:0], b};
				pfx_seen++;
				if (pfx_seen >= lfb) begin
					sz = len_acc;
					len_acc = '0;
					pfx_seen = '0;
					if (sz == 32'd1)
						ph = anfp_pkg::PH_SKIP;
					else if (sz == 32'd0 || {32'h0, sz} > blen_wide)
						ph = anfp_pkg::PH_DROP;
					else if (sz <= {16'h0, mtu}) begin
						nal_left = sz;
						open_first = 1'b1;
						ph = anfp_pkg::PH_SINGLE;
					end else begin
						nal_left = sz;
						ph = anfp_pkg::PH_FUHEAD;
					end
				end
			end
		endcase
		if (eob)
			restart_prefix();
		for (int i = 0; i < n; i++) begin
			beats[i].run_end = (i == n - 1);
			expected_beats.push_back(beats[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfb_reg = anfp_pkg::LFB_RESET;
			mtu_reg = anfp_pkg::MTU_RESET;
			restart_prefix();
			nal_left = '0;
			frag_left = '0;
			fu_ind = '0;
			fu_type = '0;
			open_first = 1'b0;
			expected_beats.delete();
			beats_pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					$error("packet_byte %0h arrived with nothing expected", packet_byte);
					mismatches++;
				end else begin
					want = expected_beats.pop_front();
					check_field("packet_byte", want.pbyte, packet_byte);
					check_field("packet_first", want.first, packet_first);
					check_field("packet_last", want.last, packet_last);
					check_field("marker_bit", want.mark, marker_bit);
					check_field("truncated", want.trunc, truncated);
					check_field("run_last", want.run_end, run_last);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					anfp_pkg::CFG_LENGTH_FIELD_BYTES: lfb_reg = cfg_wdata[2:0];
					anfp_pkg::CFG_MTU_BYTES:          mtu_reg = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				take_byte(data_byte, buffer_length, last_of_buffer);
			beats_pending = expected_beats.size();
		end
	end

endmodule

@@ bench/avc_nal_fua_packetizer_unit_test.sv @@
// ----------------------------------------------------------------------------
// avc_nal_fua_packetizer_unit_test: testbench top of the AVC NAL packetizer
// Feeds length-prefixed buffers under several prefix widths and MTUs, with
// random gaps and stalls; the packet checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module avc_nal_fua_packetizer_unit_test;

	localparam int BLEN_BITS      = 24;
	localparam int PHASE_ITEMS    = 12;      // minimum input bytes per random config phase
	localparam int DRAIN_CYCLES   = 12;      // pipeline + request queue, with margin
	localparam int SQUEEZE_CYCLES = 80;      // long receiver hold-off
	localparam int CALM_AFTER     = 170;     // no idling past this many requests

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [anfp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [15:0]                    cfg_wdata;
	logic                           in_valid;
	logic                           in_stall;
	logic [7:0]                     data_byte;
	logic [BLEN_BITS-1:0]           buffer_length;
	logic                           last_of_buffer;
	logic                           out_valid;
	logic                           out_stall;
	logic [7:0]                     packet_byte;
	logic                           packet_first;
	logic                           packet_last;
	logic                           marker_bit;
	logic                           truncated;
	logic                           run_last;

	int mismatches;
	int beats_pending;

	// stimulus bookkeeping
	int   bytes_sent;
	logic calm;          // last part of the run: no gaps, no stalls
	logic squeeze_req;   // asks the receiver for one long hold-off
	logic squeeze_done;  // the long hold-off is over

	// buffer under construction: bytes plus the length field sent with them
	logic [7:0]           buf_q[$];
	logic [BLEN_BITS-1:0] buf_len_field;

	// config plan for the random part; raw values, out-of-range ones included
	logic [2:0]  lfb_plan [8] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd7, 3'd5, 3'd2};
	logic [15:0] mtu_plan [8] = '{16'd3, 16'd5, 16'd7, 16'd65535, 16'd0, 16'd20,
	                              16'd2, 16'd9};

	avc_nal_fua_packetizer_unit #(
		.BUFFER_LENGTH_BITS(BLEN_BITS)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.buffer_length  (buffer_length),
		.last_of_buffer (last_of_buffer),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.packet_byte    (packet_byte),
		.packet_first   (packet_first),
		.packet_last    (packet_last),
		.marker_bit     (marker_bit),
		.truncated      (truncated),
		.run_last       (run_last)
	);

	anfp_packet_checker #(
		.BLEN_BITS(BLEN_BITS)
	) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.buffer_length  (buffer_length),
		.last_of_buffer (last_of_buffer),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.packet_byte    (packet_byte),
		.packet_first   (packet_first),
		.packet_last    (packet_last),
		.marker_bit     (marker_bit),
		.truncated      (truncated),
		.run_last       (run_last),
		.mismatches     (mismatches),
		.beats_pending  (beats_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop; far beyond the slowest legal run
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver: random stall bursts between stall-free runs, one long hold-off
	// on request, nothing once the run goes calm.
	// ------------------------------------------------------------------------
	initial begin
		squeeze_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze_req && !squeeze_done) begin
				// sender keeps going: queue fills, in_stall must rise
				out_stall <= 1'b1;
				repeat (SQUEEZE_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
				squeeze_done = 1'b1;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(0, 20)) @(negedge clk);
			end
		end
	end

	// One input request. Payload changes at the falling edge only; the
	// request holds until a rising edge sees in_stall low.
	task automatic send_byte(input logic [7:0] b, input logic [BLEN_BITS-1:0] blen,
			input logic eob);
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid       <= 1'b1;
		data_byte      <= b;
		buffer_length  <= blen;
		last_of_buffer <= eob;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
		calm = (bytes_sent >= CALM_AFTER);
	endtask

	task automatic send_buffer();
		for (int i = 0; i < buf_q.size(); i++)
			send_byte(buf_q[i], buf_len_field, i == buf_q.size() - 1);
	endtask

	// big-endian length prefix of the given width
	task automatic add_prefix(input int lfb, input longint value);
		for (int i = lfb - 1; i >= 0; i--)
			buf_q.push_back(8'(value >> (8 * i)));
	endtask

	// Random buffer for the current config: mostly well-formed NAL sequences
	// (single, fragmented, skip, zero length, oversized), sometimes cut short,
	// sometimes with an inflated length field, now and then pure noise.
	task automatic make_buffer(input int lfb, input int mtu);
		int nals, kind, size, full, span;
		buf_q.delete();
		span = (2 * mtu + 3 < 24) ? 2 * mtu + 3 : 24;
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(2, 12))
				buf_q.push_back(8'($urandom));
			buf_len_field = BLEN_BITS'($urandom);
		end else begin
			nals = $urandom_range(1, 3);
			for (int k = 0; k < nals; k++) begin
				kind = $urandom_range(0, 15);
				if (kind == 0) begin
					// zero length: rest of buffer dropped
					add_prefix(lfb, 0);
					buf_q.push_back(8'($urandom));
				end else if (kind == 1) begin
					// length one: the next byte is skipped
					add_prefix(lfb, 1);
					buf_q.push_back(8'($urandom));
				end else if (kind == 2) begin
					// all-ones length, normally past the buffer end
					add_prefix(lfb, (longint'(1) << (8 * lfb)) - 1);
					repeat (2)
						buf_q.push_back(8'($urandom));
				end else begin
					size = $urandom_range(2, span);
					add_prefix(lfb, size);
					repeat (size)
						buf_q.push_back(8'($urandom));
				end
			end
			full = buf_q.size();
			buf_len_field = BLEN_BITS'(full);
			// end of buffer lands anywhere: mid prefix, header, fragment
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, full - 1))
					void'(buf_q.pop_back());
			end
			if ($urandom_range(0, 7) == 0)
				buf_len_field = BLEN_BITS'($urandom) | BLEN_BITS'(full);
		end
	endtask

	// Wait for the block to go quiet: nothing left to predict, then a drain
	// wait for bytes that produce no packet output.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (beats_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_config(input logic [2:0] lfb, input logic [15:0] mtu);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= anfp_pkg::CFG_LENGTH_FIELD_BYTES;
		cfg_wdata <= {13'($urandom), lfb};
		@(negedge clk);
		cfg_index <= anfp_pkg::CFG_MTU_BYTES;
		cfg_wdata <= mtu;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int lfb_eff, mtu_eff, stop;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = anfp_pkg::CFG_LENGTH_FIELD_BYTES;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		data_byte      = '0;
		buffer_length  = '0;
		last_of_buffer = 1'b0;
		bytes_sent     = 0;
		calm           = 1'b0;
		squeeze_req    = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// --- directed, reset config: 4-byte prefix, MTU 1400 ---
		// plain single NAL
		buf_q = '{8'h00, 8'h00, 8'h00, 8'h02, 8'hE5, 8'h1A};
		buf_len_field = 24'd6;
		send_buffer();
		// partial prefix at end of buffer: thrown away, no output
		buf_q = '{8'h00, 8'h00};
		buf_len_field = 24'hFFFFFF;
		send_buffer();

		// --- directed, 1-byte prefix, minimum MTU (one payload byte per FU) ---
		set_config(3'd1, 16'd3);
		// single, skip, three-fragment NAL, zero length dropping the tail
		buf_q = '{8'h02, 8'h7F, 8'h80, 8'h01, 8'hAA, 8'h04, 8'hE5, 8'h11, 8'h22,
		          8'h33, 8'h00, 8'hC3};
		buf_len_field = 24'd12;
		send_buffer();
		// fragment ends on the last byte while NAL bytes remain
		buf_q = '{8'h05, 8'h65, 8'hA5};
		buf_len_field = 24'd5;
		send_buffer();
		// cut right after the FU header byte: nothing open yet
		buf_q = '{8'h05, 8'h41};
		buf_len_field = 24'd5;
		send_buffer();
		// single NAL cut short
		buf_q = '{8'h03, 8'h9C};
		buf_len_field = 24'd3;
		send_buffer();
		// prefix completes on the last byte
		buf_q = '{8'h02};
		buf_len_field = 24'hFFFFFF;
		send_buffer();
		// length past buffer_length (zero here): drop
		buf_q = '{8'h09, 8'h12};
		buf_len_field = 24'd0;
		send_buffer();

		// --- random part: one config per phase ---
		for (int p = 0; p < 8; p++) begin
			set_config(lfb_plan[p], mtu_plan[p]);
			lfb_eff = (lfb_plan[p] == 3'd0) ? 1 : ((lfb_plan[p] > 3'd4) ? 4 : lfb_plan[p]);
			mtu_eff = (mtu_plan[p] < 16'd3) ? 3 : mtu_plan[p];
			if (p == 1)
				squeeze_req = 1'b1;
			stop = bytes_sent + PHASE_ITEMS;
			// keep offering bytes for the whole long hold-off
			while (bytes_sent < stop || (p == 1 && !squeeze_done)) begin
				make_buffer(lfb_eff, mtu_eff);
				send_buffer();
			end
		end

		settle();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/anfp_pkg.sv
rtl/anfp_front.sv
rtl/anfp_fifo.sv
rtl/anfp_back.sv
rtl/avc_nal_fua_packetizer_unit.sv
bench/anfp_packet_checker.sv
bench/avc_nal_fua_packetizer_unit_test.sv
